// File: sv/stt_pkg.sv
// Shared request codes, status codes and the queued command type of the timer table.
`default_nettype none

package stt_pkg;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_START  = 3'd1;
    localparam logic [2:0] REQ_STOP   = 3'd2;
    localparam logic [2:0] REQ_REMOVE = 3'd3;
    localparam logic [2:0] REQ_TICK   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam int ID_BITS     = 4;
    localparam int MAX_SLOTS   = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0]         op;
        logic [ID_BITS-1:0] id;
        logic               id_ok;   // id names a slot that exists
    } stt_cmd_t;

endpackage

`default_nettype wire

// File: sv/stt_front.sv
// Request decode: drops unknown codes, range-checks the id, saturates the count.
`default_nettype none

module stt_front
    import stt_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int COUNT_BITS = 16
)
(
    input  logic                  start,
    input  logic                  full,
    input  logic [2:0]            req_type,
    input  logic [3:0]            timer_id,
    input  logic [15:0]           seconds,
    output logic                  push,
    output stt_cmd_t              cmd,
    output logic [COUNT_BITS-1:0] count
);

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF >> (32 - COUNT_BITS);

    logic [31:0] secs_wide;
    logic        known;

    assign secs_wide = {16'd0, seconds};
    assign count     = (secs_wide > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX)
                                               : COUNT_BITS'(secs_wide);

    assign known = (req_type == REQ_INSERT) || (req_type == REQ_START) ||
                   (req_type == REQ_STOP)   || (req_type == REQ_REMOVE) ||
                   (req_type == REQ_TICK);

    assign push      = start & ~full & known;
    assign cmd.op    = req_type;
    assign cmd.id    = timer_id;
    assign cmd.id_ok = ({1'b0, timer_id} < 5'(SLOTS));

endmodule

`default_nettype wire

// File: sv/stt_queue.sv
// Short command queue between the decode front and the table engine.
`default_nettype none

module stt_queue
    import stt_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty,
    output logic         full
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;

    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == CW'(QUEUE_DEPTH));
    assign dout  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

endmodule

`default_nettype wire

// File: sv/stt_back.sv
// Table engine: slot flags, counts, and the one-slot-per-cycle tick walk.
`default_nettype none

module stt_back
    import stt_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int COUNT_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  empty,
    input  stt_cmd_t              cmd,
    input  logic [COUNT_BITS-1:0] count,
    output logic                  pop,
    output logic                  done,
    output logic [1:0]            status,
    output logic [3:0]            result_id,
    output logic                  expired,
    output logic                  last
);

    localparam int IW = $clog2(SLOTS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [SLOTS-1:0]      used_reg, used_next;
    logic [SLOTS-1:0]      armed_reg, armed_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic                  held_reg, held_next;
    logic [IW-1:0]         held_id_reg, held_id_next;
    logic [COUNT_BITS-1:0] count_reg [SLOTS];

    logic                  done_reg, done_next;
    logic [1:0]            status_reg, status_next;
    logic [3:0]            id_reg, id_next;
    logic                  expired_reg, expired_next;
    logic                  last_reg, last_next;

    logic                  free_found;
    logic [IW-1:0]         free_idx;
    logic [IW-1:0]         cmd_slot;
    logic                  slot_hit;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic                  walk_live;
    logic                  walk_expire;
    logic                  cnt_we;
    logic [IW-1:0]         cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign cmd_slot    = cmd.id[IW-1:0];
    assign slot_hit    = cmd.id_ok && used_reg[cmd_slot];
    assign cur_cnt     = count_reg[idx_reg];
    assign walk_live   = used_reg[idx_reg] & armed_reg[idx_reg];
    assign walk_expire = walk_live && (cur_cnt <= COUNT_BITS'(1));

    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        armed_next   = armed_reg;
        idx_next     = idx_reg;
        held_next    = held_reg;
        held_id_next = held_id_reg;
        done_next    = 1'b0;
        status_next  = ST_OK;
        id_next      = '0;
        expired_next = 1'b0;
        last_next    = 1'b0;
        pop          = 1'b0;
        cnt_we       = 1'b0;
        cnt_waddr    = cmd_slot;
        cnt_wdata    = count;

        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    case (cmd.op)
                        REQ_INSERT:
                        begin
                            done_next = 1'b1;
                            last_next = 1'b1;
                            if (free_found)
                            begin
                                used_next[free_idx]  = 1'b1;
                                armed_next[free_idx] = 1'b0;
                                id_next              = 4'(free_idx);
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        REQ_START:
                        begin
                            done_next = 1'b1;
                            last_next = 1'b1;
                            id_next   = cmd.id;
                            if (slot_hit)
                            begin
                                armed_next[cmd_slot] = 1'b1;
                                cnt_we               = 1'b1;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        REQ_STOP, REQ_REMOVE:
                        begin
                            done_next = 1'b1;
                            last_next = 1'b1;
                            id_next   = cmd.id;
                            if (slot_hit)
                            begin
                                armed_next[cmd_slot] = 1'b0;
                                if (cmd.op == REQ_REMOVE)
                                begin
                                    used_next[cmd_slot] = 1'b0;
                                end
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        REQ_TICK:
                        begin
                            state_next = S_WALK;
                            idx_next   = '0;
                            held_next  = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (walk_expire)
                begin
                    used_next[idx_reg]  = 1'b0;
                    armed_next[idx_reg] = 1'b0;
                    held_next           = 1'b1;
                    held_id_next        = idx_reg;
                    // a newer expiry means the held one is not the last
                    if (held_reg)
                    begin
                        done_next    = 1'b1;
                        expired_next = 1'b1;
                        id_next      = 4'(held_id_reg);
                    end
                end
                else if (walk_live)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = idx_reg;
                    cnt_wdata = cur_cnt - 1'b1;
                end
                if (idx_reg == IW'(SLOTS - 1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                done_next    = 1'b1;
                last_next    = 1'b1;
                expired_next = held_reg;
                id_next      = held_reg ? 4'(held_id_reg) : 4'd0;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            armed_reg <= '0;
            held_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            armed_reg <= armed_next;
            held_reg  <= held_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        held_id_reg <= held_id_next;
        status_reg  <= status_next;
        id_reg      <= id_next;
        expired_reg <= expired_next;
        last_reg    <= last_next;
        if (cnt_we)
        begin
            count_reg[cnt_waddr] <= cnt_wdata;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign result_id = id_reg;
    assign expired   = expired_reg;
    assign last      = last_reg;

    a_armed_used: assert property (@(posedge clk) disable iff (!rst_n)
        (armed_reg & ~used_reg) == '0)
        else $error("armed slot is not allocated");

    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN |=> done_reg && last_reg)
        else $error("tick walk ended without a final result");

    a_walk_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) && done_reg |-> expired_reg && !last_reg)
        else $error("result during walk is not an inner expiry");

    a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && expired_reg |-> status_reg == ST_OK)
        else $error("expiry result with error status");

endmodule

`default_nettype wire

// File: sv/software_timer_table_unit.sv
// Top level of the countdown timer table: decode front, command queue, table engine.
//
//  channel  | ports                                          | transfer
//  ---------+------------------------------------------------+------------------------------
//  request  | start, busy, req_type, timer_id, seconds       | start high while busy low
//  result   | done, status, result_id, expired, last         | done high, one cycle each
//
// Timing:
//  - A request is decoded in the cycle it is taken and lands in a two-entry queue;
//    busy is high while that queue is full. Unknown request codes are taken and dropped.
//  - Insert, start, stop and remove are handled without leaving the idle state; their result
//    shows on the ports the cycle after the engine picks them up.
//  - A tick is picked up in the idle state, then walks all min(NUM_TIMERS,16) slots in
//    turn over the single count read/decrement path, then closes in a final state.
//    Expiries come out in ascending slot order, each in the cycle after the next expiry
//    is found, the final one (last high) the cycle after the close.
//  - Reset clears all slot flags at once; counts are loaded by start before use,
//    so no clearing pass is needed. The receiver cannot stall the result channel.
`default_nettype none

module software_timer_table_unit
    import stt_pkg::*;
#(
    parameter int NUM_TIMERS = 16,
    parameter int COUNT_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [2:0]  req_type,
    input  wire logic [3:0]  timer_id,
    input  wire logic [15:0] seconds,
    output logic             busy,
    output logic             done,
    output logic [1:0]       status,
    output logic [3:0]       result_id,
    output logic             expired,
    output logic             last
);

    // ids are four bits wide, so at most sixteen slots are reachable
    localparam int SLOTS = (NUM_TIMERS < MAX_SLOTS) ? NUM_TIMERS : MAX_SLOTS;
    localparam int QW    = $bits(stt_cmd_t) + COUNT_BITS;

    logic                  push;
    logic                  pop;
    logic                  q_empty;
    logic                  q_full;
    stt_cmd_t              f_cmd;
    logic [COUNT_BITS-1:0] f_count;
    logic [QW-1:0]         q_dout;
    stt_cmd_t              q_cmd;
    logic [COUNT_BITS-1:0] q_count;

    assign busy = q_full;

    stt_front #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .start    (start),
        .full     (q_full),
        .req_type (req_type),
        .timer_id (timer_id),
        .seconds  (seconds),
        .push     (push),
        .cmd      (f_cmd),
        .count    (f_count)
    );

    stt_queue #(
        .W (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   ({f_cmd, f_count}),
        .pop   (pop),
        .dout  (q_dout),
        .empty (q_empty),
        .full  (q_full)
    );

    assign {q_cmd, q_count} = q_dout;

    stt_back #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .cmd       (q_cmd),
        .count     (q_count),
        .pop       (pop),
        .done      (done),
        .status    (status),
        .result_id (result_id),
        .expired   (expired),
        .last      (last)
    );

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the countdown timer table: directed and random request traffic.
`timescale 1ns / 1ps

module tb_top;
    import stt_pkg::*;

    // Request codes the block takes and drops without a result
    localparam logic [2:0] REQ_BAD_LO = 3'd5;
    localparam logic [2:0] REQ_BAD_HI = 3'd7;

    // Far longer than a full tick walk with two more requests waiting in the queue
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [1:0] status;
        logic [3:0] id;
        logic       expired;
        logic       last;
    } timer_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic [2:0]  req_type;
    logic [3:0]  timer_id;
    logic [15:0] seconds;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [3:0]  result_id;
    logic        expired;
    logic        last;

    // Shadow copy of the table, updated at each request transfer
    logic        slot_used  [MAX_SLOTS];
    logic        slot_armed [MAX_SLOTS];
    logic [15:0] slot_count [MAX_SLOTS];

    timer_result_t pending_results[$];
    timer_result_t oldest;
    int            mismatch_count = 0;
    int            stall_cycles   = 0;
    bit            gaps_on        = 1'b1;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    software_timer_table_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req_type),
        .timer_id  (timer_id),
        .seconds   (seconds),
        .busy      (busy),
        .done      (done),
        .status    (status),
        .result_id (result_id),
        .expired   (expired),
        .last      (last)
    );

    // ------------------------------------------------------------------
    // Table model: turns one accepted request into the results it owes
    // ------------------------------------------------------------------
    task automatic push_result(input logic [1:0] st, input logic [3:0] id,
                               input logic exp, input logic fin);
        timer_result_t r;
        r.status  = st;
        r.id      = id;
        r.expired = exp;
        r.last    = fin;
        pending_results.push_back(r);
    endtask

    task automatic model_request(input logic [2:0] op, input logic [3:0] id,
                                 input logic [15:0] secs);
        int  free_slot;
        int  fired;
        int  last_fired;
        free_slot  = -1;
        fired      = 0;
        last_fired = 0;
        case (op)
            REQ_INSERT:
            begin
                // lowest free slot wins; ids are slot indices
                for (int i = MAX_SLOTS - 1; i >= 0; i--)
                    if (!slot_used[i])
                        free_slot = i;
                if (free_slot < 0)
                    push_result(ST_FULL, 4'd0, 1'b0, 1'b1);
                else
                begin
                    slot_used[free_slot]  = 1'b1;
                    slot_armed[free_slot] = 1'b0;
                    push_result(ST_OK, 4'(free_slot), 1'b0, 1'b1);
                end
            end
            REQ_START, REQ_STOP, REQ_REMOVE:
            begin
                if (!slot_used[id])
                    push_result(ST_NOT_FOUND, id, 1'b0, 1'b1);
                else
                begin
                    // start reloads even an armed slot; stop keeps the count
                    slot_armed[id] = (op == REQ_START);
                    if (op == REQ_START)
                        slot_count[id] = secs;
                    if (op == REQ_REMOVE)
                        slot_used[id] = 1'b0;
                    push_result(ST_OK, id, 1'b0, 1'b1);
                end
            end
            REQ_TICK:
            begin
                // a count of 0 or 1 fires on this tick and frees the slot
                for (int i = 0; i < MAX_SLOTS; i++)
                begin
                    if (slot_used[i] && slot_armed[i])
                    begin
                        if (slot_count[i] <= 16'd1)
                        begin
                            slot_used[i]  = 1'b0;
                            slot_armed[i] = 1'b0;
                            push_result(ST_OK, 4'(i), 1'b1, 1'b0);
                            fired++;
                        end
                        else
                            slot_count[i] = slot_count[i] - 16'd1;
                    end
                end
                if (fired == 0)
                    push_result(ST_OK, 4'd0, 1'b0, 1'b1);
                else
                begin
                    last_fired = pending_results.size() - 1;
                    pending_results[last_fired].last = 1'b1;
                end
            end
            default:
            begin
                // dropped request codes leave no trace
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request side. start is left high after a transfer so that
    // back-to-back requests never lower and raise it in one step.
    // ------------------------------------------------------------------
    task automatic send_req(input logic [2:0] op, input logic [3:0] id,
                            input logic [15:0] secs);
        start    <= 1'b1;
        req_type <= op;
        timer_id <= id;
        seconds  <= secs;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        model_request(op, id, secs);
    endtask

    task automatic sender_gap(input int cycles);
        start    <= 1'b0;
        req_type <= 3'($urandom);
        timer_id <= 4'($urandom);
        seconds  <= 16'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_gap();
        if (gaps_on && $urandom_range(0, 3) == 0)
            sender_gap($urandom_range(1, 6));
    endtask

    // Hold off until the table has answered everything sent so far
    task automatic wait_table_quiet();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly names a slot that is in use, so start/stop/remove get past the lookup
    function automatic logic [3:0] pick_slot();
        int live[$];
        for (int i = 0; i < MAX_SLOTS; i++)
            if (slot_used[i])
                live.push_back(i);
        if (live.size() != 0 && $urandom_range(0, 9) < 8)
            return 4'(live[$urandom_range(0, live.size() - 1)]);
        return 4'($urandom);
    endfunction

    task automatic send_random_req();
        int          pick;
        logic [2:0]  op;
        logic [3:0]  id;
        logic [15:0] secs;
        pick = $urandom_range(0, 99);
        id   = pick_slot();
        // short counts so timers actually fire; now and then a full-width one
        secs = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        if (pick < 20)
            op = REQ_INSERT;
        else if (pick < 50)
            op = REQ_START;
        else if (pick < 58)
            op = REQ_STOP;
        else if (pick < 66)
            op = REQ_REMOVE;
        else if (pick < 96)
            op = REQ_TICK;
        else
            op = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
        send_req(op, id, secs);
        maybe_gap();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_empty_table();
        send_req(REQ_TICK, 4'hF, 16'hFFFF);     // nothing armed: single plain result
        send_req(REQ_REMOVE, 4'hF, 16'h0000);   // free slot: not found
        send_req(REQ_START, 4'h0, 16'h0001);    // free slot: not found
    endtask

    task automatic test_fill_table();
        for (int i = 0; i < MAX_SLOTS; i++)
            send_req(REQ_INSERT, 4'($urandom), 16'($urandom));
        send_req(REQ_INSERT, 4'h0, 16'h0000);   // table full
    endtask

    task automatic test_timer_controls();
        send_req(REQ_START, 4'h0, 16'h0000);    // zero count fires on next tick
        send_req(REQ_START, 4'h1, 16'h0001);
        send_req(REQ_START, 4'hF, 16'hFFFF);
        send_req(REQ_START, 4'hF, 16'h0003);    // restart reloads the count
        send_req(REQ_STOP, 4'hF, 16'h0000);
        send_req(REQ_STOP, 4'hF, 16'h0000);     // stop on a stopped slot is fine
        send_req(REQ_TICK, 4'h0, 16'h0000);     // slots 0 and 1 expire, in order
        send_req(REQ_BAD_LO, 4'h0, 16'h0000);
        send_req(REQ_BAD_HI, 4'hF, 16'hFFFF);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_random_req();
    endtask

    task automatic test_quiet_pause();
        wait_table_quiet();
        send_req(REQ_TICK, 4'($urandom), 16'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Result checker: every done cycle is a transfer, matched in order
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t mismatch: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                note_mismatch($sformatf("unexpected result status=%0d id=%0d exp=%0b last=%0b",
                                        status, result_id, expired, last));
            else
            begin
                oldest = pending_results.pop_front();
                if (status !== oldest.status || result_id !== oldest.id ||
                    expired !== oldest.expired || last !== oldest.last)
                    note_mismatch($sformatf(
                        "expected status=%0d id=%0d exp=%0b last=%0b, got %0d %0d %0b %0b",
                        oldest.status, oldest.id, oldest.expired, oldest.last,
                        status, result_id, expired, last));
            end
        end
    end

    // Watchdog: too long with neither a request nor a result transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired, %0d results outstanding", pending_results.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        req_type = REQ_INSERT;
        timer_id = 4'd0;
        seconds  = 16'd0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            slot_used[i]  = 1'b0;
            slot_armed[i] = 1'b0;
            slot_count[i] = 16'd0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_fill_table();
        test_timer_controls();
        test_random_traffic(90);
        test_quiet_pause();
        test_random_traffic(80);
        // closing stretch runs back to back
        gaps_on = 1'b0;
        test_random_traffic(50);

        wait_table_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
sv/stt_pkg.sv
sv/stt_front.sv
sv/stt_queue.sv
sv/stt_back.sv
sv/software_timer_table_unit.sv
verif/tb_top.sv
